[design/rgbablend_pkg.sv]
// Shared types and constants for the RGBA source-over blend pipeline.
// No dependencies; used by rgba_alpha_blend_over.
`default_nettype none

package rgbablend_pkg;

    // Channel count carried through the divider (B, G, R)
    localparam int NUM_COLORS = 3;

    // Pipeline: two multiply stages, one sum stage, then one stage per quotient bit
    localparam int QUO_BITS   = 8;
    localparam int NUM_STAGES = 3 + QUO_BITS;

    // floor(n / 255) == (n * 32897) >> 23 for every n up to 255*255
    localparam logic [15:0] ALPHA_RECIP = 16'd32897;
    localparam int          ALPHA_SHIFT = 23;

    // One divider stage word: weight sum, finished alpha, running remainders and quotients
    typedef struct packed {
        logic [16:0]                       n;
        logic [7:0]                        alpha;
        logic [NUM_COLORS-1:0][23:0]       rem;
        logic [NUM_COLORS-1:0][QUO_BITS-1:0] quo;
    } quot_stage_t;

endpackage

`default_nettype wire

[design/rgba_alpha_blend_over.sv]
// Straight-alpha source-over compositing of two packed RGBA words, pipelined.
// Depends on rgbablend_pkg (stage word type, reciprocal constant).
// Pipeline: eleven register stages from the accepting input edge to output valid.
// Throughput: one pixel per clock while the output is not stalled; the restoring divider is unrolled one bit per stage.
// Backpressure collapses bubbles: each stage loads when it is empty or its successor moves.
// Reset (rst_n low, asynchronous) clears every stage valid bit; payload is not reset.
// Both alphas zero gives an all-zero output word.
`default_nettype none

module rgba_alpha_blend_over
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // [31:0] bottom_pixel, [63:32] top_pixel

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [31:0] blended_pixel
);

    localparam int NS = rgbablend_pkg::NUM_STAGES;
    localparam int NC = rgbablend_pkg::NUM_COLORS;
    localparam int QB = rgbablend_pkg::QUO_BITS;

    // Stage map: 0 = weights, 1 = products, 2 = numerators/alpha, 3..10 = quotient bits
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] adv;

    // Stage 0 payload
    logic [15:0]          wt_reg, wt_next;
    logic [15:0]          wb_reg, wb_next;
    logic [NC-1:0][7:0]   ct_reg, ct_next;
    logic [NC-1:0][7:0]   cb_reg, cb_next;

    // Stage 1 payload
    logic [16:0]          n_reg, n_next;
    logic [NC-1:0][23:0]  pt_reg, pt_next;
    logic [NC-1:0][23:0]  pb_reg, pb_next;

    // Stages 2..10: divider words
    rgbablend_pkg::quot_stage_t dv_reg  [0:QB];
    rgbablend_pkg::quot_stage_t dv_next [0:QB];

    logic [7:0]  at;
    logic [7:0]  ab;
    logic [32:0] alpha_prod;

    // ---------------------------------------------------------------
    // Handshake: ready ripples back from the output, bubbles are absorbed
    // ---------------------------------------------------------------
    always_comb
    begin
        adv[NS-1] = !vld_reg[NS-1] || m_axis_tready;
        for (int k = NS-2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    always_comb
    begin
        vld_next = vld_reg;
        if (adv[0])
        begin
            vld_next[0] = s_axis_tvalid;
        end
        for (int k = 1; k < NS; k++)
        begin
            if (adv[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: alpha weights wt = aT*255, wb = aB*(255-aT)
    // ---------------------------------------------------------------
    assign at = s_axis_tdata[39:32];
    assign ab = s_axis_tdata[7:0];

    always_comb
    begin
        wt_next = {at, 8'd0} - {8'd0, at};
        wb_next = {8'd0, ab} * {8'd0, 8'd255 - at};
        for (int c = 0; c < NC; c++)
        begin
            // channel c sits at bit 8*(c+1): B, G, R
            cb_next[c] = s_axis_tdata[8*(c+1) +: 8];
            ct_next[c] = s_axis_tdata[32 + 8*(c+1) +: 8];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            wt_reg <= wt_next;
            wb_reg <= wb_next;
            ct_reg <= ct_next;
            cb_reg <= cb_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: weight sum and per-channel weighted products
    // ---------------------------------------------------------------
    always_comb
    begin
        n_next = {1'b0, wt_reg} + {1'b0, wb_reg};
        for (int c = 0; c < NC; c++)
        begin
            pt_next[c] = {16'd0, ct_reg[c]} * {8'd0, wt_reg};
            pb_next[c] = {16'd0, cb_reg[c]} * {8'd0, wb_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            n_reg  <= n_next;
            pt_reg <= pt_next;
            pb_reg <= pb_next;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: numerators, alpha by reciprocal multiply
    // Numerator is at most 255*n, so it fits in 24 bits.
    // ---------------------------------------------------------------
    assign alpha_prod = {16'd0, n_reg} * {17'd0, rgbablend_pkg::ALPHA_RECIP};

    always_comb
    begin
        dv_next[0].n     = n_reg;
        dv_next[0].alpha = alpha_prod[rgbablend_pkg::ALPHA_SHIFT +: 8];
        dv_next[0].quo   = '0;
        for (int c = 0; c < NC; c++)
        begin
            dv_next[0].rem[c] = pt_reg[c] + pb_reg[c];
        end
    end

    // ---------------------------------------------------------------
    // Stages 3..10: restoring divide, one quotient bit per stage, MSB first.
    // Quotient never exceeds 255, so 8 bits are enough.
    // ---------------------------------------------------------------
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int BITPOS = QB - 1 - j;

        logic [23:0] shf;

        assign shf = 24'(dv_reg[j].n) << BITPOS;

        always_comb
        begin
            logic [24:0] trial;
            dv_next[j+1] = dv_reg[j];
            for (int c = 0; c < NC; c++)
            begin
                trial = {1'b0, dv_reg[j].rem[c]} - {1'b0, shf};
                if (!trial[24])
                begin
                    dv_next[j+1].rem[c]         = trial[23:0];
                    dv_next[j+1].quo[c][BITPOS] = 1'b1;
                end
            end
        end
    end

    for (genvar k = 0; k <= QB; k++)
    begin : g_dv_reg
        always_ff @(posedge clk)
        begin
            if (adv[k+2])
            begin
                dv_reg[k] <= dv_next[k];
            end
        end
    end

    // ---------------------------------------------------------------
    // Output: zero weight sum means both alphas were zero -> all zeros
    // ---------------------------------------------------------------
    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tdata  = (dv_reg[QB].n == '0) ? 32'd0 :
                           {dv_reg[QB].quo[2], dv_reg[QB].quo[1],
                            dv_reg[QB].quo[0], dv_reg[QB].alpha};

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // Reciprocal alpha must equal floor(n/255)
    a_alpha_exact: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> (({9'd0, dv_reg[0].alpha} * 17'd255) <= dv_reg[0].n) &&
                       (dv_reg[0].n < (({9'd0, dv_reg[0].alpha} * 17'd255) + 17'd255)))
        else $error("alpha reciprocal mismatch");

    // Divider finishes with every remainder below the divisor
    a_rem_below_n: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NS-1] && (dv_reg[QB].n != '0)) |->
            (dv_reg[QB].rem[0] < 24'(dv_reg[QB].n)) &&
            (dv_reg[QB].rem[1] < 24'(dv_reg[QB].n)) &&
            (dv_reg[QB].rem[2] < 24'(dv_reg[QB].n)))
        else $error("divider remainder not reduced");

    // A blocked stage 2 (first divider word) keeps its word
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[2] && !adv[3]) |=> (vld_reg[2] && $stable(dv_reg[0])))
        else $error("stalled stage lost its word");

    // Input is refused only when every stage is occupied
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg))
        else $error("input blocked with a bubble in the pipeline");

endmodule

`default_nettype wire
